@@ sv/utf16_to_utf8_converter_assert.svh @@
// Assertion macros used by the converter back end.
`ifndef UTF16_TO_UTF8_CONVERTER_ASSERT_SVH
`define UTF16_TO_UTF8_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define U16U8_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u16u8 assertion failed");

// Next-cycle implication, checked outside reset.
`define U16U8_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u16u8 assertion failed");

`endif

@@ sv/u16u8_pkg.sv @@
// Types, constants and the UTF-8 encoder shared by the converter modules.
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

  localparam logic [15:0] HIGH_FIRST = 16'hD800;
  localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] LOW_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  // Classified word as it sits in the queue between front and back.
  typedef struct packed {
    logic [15:0] unit;
    logic        is_high;
    logic        is_low;
    logic        last;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic [2:0]  count;
  } enc_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t r;
    r.bytes = '0;
    r.count = 3'd0;
    if (cp < 21'h80) begin
      r.bytes = {1'b0, cp[6:0], 24'h0};
      r.count = 3'd1;
    end else if (cp < 21'h800) begin
      r.bytes = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
      r.count = 3'd2;
    end else if (cp < SUPP_BASE) begin
      r.bytes = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
      r.count = 3'd3;
    end else begin
      r.bytes = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                 2'b10, cp[5:0]};
      r.count = 3'd4;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/u16u8_front.sv @@
// Front end: input handshake, byte swap, surrogate classification, two-word queue.
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front import u16u8_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_last_unit,
  output q_head_t          head,
  input  wire logic        pop
);

  logic        little_endian_r;
  q_item_t     q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        wr_ptr_nxt, rd_ptr_nxt;
  logic [1:0]  count_nxt;
  logic        push;
  logic [15:0] unit;
  q_item_t     item;

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    unit = little_endian_r ? {in_code_unit[7:0], in_code_unit[15:8]} : in_code_unit;
    item.unit    = unit;
    item.is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
    item.is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
    item.last    = in_last_unit;
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      little_endian_r <= 1'b0;
      wr_ptr_r        <= 1'b0;
      rd_ptr_r        <= 1'b0;
      count_r         <= 2'd0;
    end else begin
      if (cfg_we) begin
        little_endian_r <= cfg_wdata;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule
`default_nettype wire

@@ sv/u16u8_back.sv @@
// Back end: surrogate pairing, error tracking, UTF-8 encoding, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_converter_assert.svh"
module u16u8_back import u16u8_pkg::*; #(
  parameter int MAX_UNITS = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire q_head_t     head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_bytes,
  output logic [2:0]       out_byte_count,
  output logic [1:0]       out_status,
  output logic [15:0]      out_error_index,
  output logic [17:0]      out_total_bytes,
  output logic             out_done_res
);

  localparam int IDX_CAP_I = (MAX_UNITS > 65536) ? 65535 : MAX_UNITS - 1;
  localparam int TOT_CAP_I = (MAX_UNITS > 65536) ? 262143 : 4 * MAX_UNITS - 1;
  localparam logic [15:0] IDX_CAP = IDX_CAP_I[15:0];
  localparam logic [18:0] TOT_CAP = TOT_CAP_I[18:0];

  // string state
  logic        pend_r, pend_nxt;
  logic [9:0]  hbits_r, hbits_nxt;
  logic [15:0] hidx_r, hidx_nxt;
  logic [15:0] uidx_r, uidx_nxt;
  logic [17:0] total_r, total_nxt;
  logic        err_r, err_nxt;
  logic [15:0] epos_r, epos_nxt;

  // output register
  logic        out_valid_r;
  logic [31:0] bytes_r, bytes_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  status_t     status_r, status_nxt;
  logic [15:0] eidx_r, eidx_nxt;
  logic [17:0] tot_r, tot_nxt;
  logic        done_r;

  q_item_t     it;
  logic [20:0] cp;
  enc_t        enc;
  logic        emit;
  logic        fault;
  logic [15:0] fault_at;
  logic [18:0] sum;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid_r || !out_stall);

  always_comb begin
    cp  = pend_r ? ({1'b0, hbits_r, it.unit[9:0]} + SUPP_BASE) : {5'b0, it.unit};
    enc = utf8_encode(cp);
  end

  always_comb begin
    pend_nxt  = pend_r;
    hbits_nxt = hbits_r;
    hidx_nxt  = hidx_r;
    uidx_nxt  = uidx_r;
    total_nxt = total_r;
    err_nxt   = err_r;
    epos_nxt  = epos_r;
    emit      = 1'b0;
    fault     = 1'b0;
    fault_at  = uidx_r;
    sum       = '0;
    bytes_nxt  = '0;
    cnt_nxt    = 3'd0;
    status_nxt = ST_BUSY;
    eidx_nxt   = '0;
    tot_nxt    = '0;

    if (!err_r) begin
      priority if (pend_r) begin
        pend_nxt = 1'b0;
        if (it.is_low) begin
          emit = 1'b1;
        end else begin
          // pair broken: blame the high half, swallow this word
          fault    = 1'b1;
          fault_at = hidx_r;
        end
      end else if (it.is_high) begin
        if (it.last) begin
          fault = 1'b1;
        end else begin
          pend_nxt  = 1'b1;
          hbits_nxt = it.unit[9:0];
          hidx_nxt  = uidx_r;
        end
      end else if (it.is_low) begin
        fault = 1'b1;
      end else begin
        emit = 1'b1;
      end

      if (fault) begin
        err_nxt  = 1'b1;
        epos_nxt = fault_at;
        pend_nxt = 1'b0;
      end
      if (emit) begin
        bytes_nxt = enc.bytes;
        cnt_nxt   = enc.count;
      end
      sum       = {1'b0, total_r} + {16'b0, cnt_nxt};
      total_nxt = (sum > TOT_CAP) ? TOT_CAP[17:0] : sum[17:0];
    end

    if (it.last) begin
      if (err_nxt) begin
        status_nxt = ST_ERR;
        eidx_nxt   = epos_nxt;
      end else begin
        status_nxt = ST_OK;
        tot_nxt    = total_nxt;
      end
      pend_nxt  = 1'b0;
      hbits_nxt = '0;
      hidx_nxt  = '0;
      uidx_nxt  = '0;
      total_nxt = '0;
      err_nxt   = 1'b0;
      epos_nxt  = '0;
    end else if (uidx_r < IDX_CAP) begin
      uidx_nxt = uidx_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      hbits_r     <= '0;
      hidx_r      <= '0;
      uidx_r      <= '0;
      total_r     <= '0;
      err_r       <= 1'b0;
      epos_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        pend_r  <= pend_nxt;
        hbits_r <= hbits_nxt;
        hidx_r  <= hidx_nxt;
        uidx_r  <= uidx_nxt;
        total_r <= total_nxt;
        err_r   <= err_nxt;
        epos_r  <= epos_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes_r  <= bytes_nxt;
      cnt_r    <= cnt_nxt;
      status_r <= status_nxt;
      eidx_r   <= eidx_nxt;
      tot_r    <= tot_nxt;
      done_r   <= it.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bytes       = bytes_r;
  assign out_byte_count  = cnt_r;
  assign out_status      = status_r;
  assign out_error_index = eidx_r;
  assign out_total_bytes = tot_r;
  assign out_done_res    = done_r;

  // a closing status only ever rides on the last word of a string
  `U16U8_ASSERT_IMPL(a_status_on_close, clk, rst_n,
    out_valid_r && (status_r != ST_BUSY), done_r)
  // a failed string never carries bytes on its closing word
  `U16U8_ASSERT_IMPL(a_err_no_bytes, clk, rst_n,
    out_valid_r && (status_r == ST_ERR), cnt_r == 3'd0)
  // once the string is in error no high half is held
  `U16U8_ASSERT_IMPL(a_err_clears_pend, clk, rst_n, err_r, !pend_r)
  // a popped last word leaves the string state cleared
  `U16U8_ASSERT_NEXT(a_last_clears, clk, rst_n,
    pop && it.last, !pend_r && !err_r && (uidx_r == 16'd0))

endmodule
`default_nettype wire

@@ sv/utf16_to_utf8_converter.sv @@
// UTF-16 to UTF-8 converter top level.
// Takes one UTF-16 code unit per word and returns one result word per input word,
// carrying the 0 to 4 UTF-8 bytes of a completed code point (first byte in
// bits 31..24). Sustained rate is one word per clock while out_stall is low. An
// accepted word is written into the two-word queue, where the decode logic reads
// it; its result is then loaded into the output register, unless out_stall holds
// an earlier result there. in_stall rises only when the queue holds two words,
// which happens only while out_stall holds a result in the output register. The
// decode stage holds the pending high surrogate and the per-string counters, so
// it is the only serial point: one word per cycle through it when not stalled.
// cfg_wdata = 1 byte-swaps input units (little-endian storage); write it only
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module utf16_to_utf8_converter import u16u8_pkg::*; #(
  parameter int MAX_UNITS = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_last_unit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_bytes,
  output logic [2:0]       out_byte_count,
  output logic [1:0]       out_status,
  output logic [15:0]      out_error_index,
  output logic [17:0]      out_total_bytes,
  output logic             out_done_res
);

  q_head_t head;
  logic    pop;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .in_last_unit (in_last_unit),
    .head         (head),
    .pop          (pop)
  );

  u16u8_back #(
    .MAX_UNITS (MAX_UNITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bytes       (out_bytes),
    .out_byte_count  (out_byte_count),
    .out_status      (out_status),
    .out_error_index (out_error_index),
    .out_total_bytes (out_total_bytes),
    .out_done_res    (out_done_res)
  );

endmodule
`default_nettype wire
